### src/count_min_sketch_engine_unit_assert.svh
// Assertion macros shared by the sketch engine modules.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef COUNT_MIN_SKETCH_ENGINE_UNIT_ASSERT_SVH
`define COUNT_MIN_SKETCH_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define CMS_ASSERT(label, ante, cons) label: assert property (@(posedge clk) \
	disable iff (!arst_n) (ante) |-> (cons)) else $error("sketch engine check failed");
// Next-cycle implication.
`define CMS_ASSERT_NEXT(label, ante, cons) label: assert property (@(posedge clk) \
	disable iff (!arst_n) (ante) |=> (cons)) else $error("sketch engine check failed");
`else
`define CMS_ASSERT(label, ante, cons)
`define CMS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### src/cms_pkg.sv
package cms_pkg;
	// Default sizes of the counter store.
	localparam int unsigned DEF_MAX_COLUMNS  = 4096;
	localparam int unsigned DEF_MAX_ROWS     = 8;
	localparam int unsigned DEF_COUNTER_BITS = 32;

	// Longest key that is hashed; longer lengths saturate.
	localparam int unsigned KEY_BYTES = 16;

	// Register reset values.
	localparam logic [12:0] ROW_WIDTH_RESET = 13'd2000;
	localparam logic [3:0]  ROW_COUNT_RESET = 4'd7;

	// Configuration register indexes.
	typedef enum logic [3:0] {
		CFG_ROW_WIDTH = 4'd0,
		CFG_ROW_COUNT = 4'd1
	} cfg_index_t;

	// Request kind carried in tuser.
	localparam logic REQ_INCREASE = 1'b0;
	localparam logic REQ_ESTIMATE = 1'b1;

	// Hash constants.
	localparam logic [63:0] MM_C1   = 64'h87c37b91114253d5;
	localparam logic [63:0] MM_C2   = 64'h4cf5ad432745937f;
	localparam logic [63:0] MM_FM1  = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MM_FM2  = 64'hc4ceb9fe1a85ec53;
	localparam logic [63:0] MM_ADD1 = 64'h0000000052dce729;
	localparam logic [63:0] MM_ADD2 = 64'h0000000038495ab5;

	// Control part of one counter operation passed from front to back.
	typedef struct packed {
		logic has_op;
		logic last;
		logic is_est;
	} op_ctl_t;

	function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic logic [63:0] xshift33(input logic [63:0] x);
		return x ^ (x >> 33);
	endfunction
endpackage

### src/count_min_sketch_engine_unit.sv
// Channel | Direction | Signals                      | Content
// s       | in        | s_tvalid s_tready s_tdata/tuser | one sketch request
// m       | out       | m_tvalid m_tready m_tdata    | one result per request
// cfg     | in        | cfg_valid cfg_ready cfg_index cfg_data | register writes
//
// Per row pair the front end computes eight 64-bit products on one shared 32x32 multiplier
// and runs nine mixing steps; per column it then reduces the hash to a remainder and hands
// the counter address to the back end.
// The back end reads one counter per row, updates it on an increase, and then posts the result.
// After reset every counter of the store is swept to zero before any request is taken.
// A four-entry queue lets the hash run ahead while the store or the output is stalled.
module count_min_sketch_engine_unit #(
	parameter int unsigned MAX_COLUMNS  = cms_pkg::DEF_MAX_COLUMNS,
	parameter int unsigned MAX_ROWS     = cms_pkg::DEF_MAX_ROWS,
	parameter int unsigned COUNTER_BITS = cms_pkg::DEF_COUNTER_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// key_lo[63:0], key_hi[127:64], key_len[132:128], amount[164:133], zero fill
	input  logic [167:0] s_tdata,
	// req_type[0]
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// estimate[31:0], was_new[32], distinct_total[64:33], zero fill
	output logic [71:0]  m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [3:0]   cfg_index,
	input  logic [15:0]  cfg_data
);
	import cms_pkg::*;

	localparam int unsigned ADDR_W = $clog2(MAX_ROWS * MAX_COLUMNS);

	logic [12:0]        row_width_q;
	logic [3:0]         row_count_q;
	logic               push_valid, push_ready, clear_done;
	op_ctl_t            push_ctl;
	logic [ADDR_W-1:0]  push_addr;
	logic signed [31:0] push_amount;
	logic [31:0]        estimate, distinct_total;
	logic               was_new;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_RESET;
			row_count_q <= ROW_COUNT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ROW_WIDTH: row_width_q <= cfg_data[12:0];
				CFG_ROW_COUNT: row_count_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	cms_front #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS),
		.ADDR_W      (ADDR_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_is_est   (s_tuser[0] == REQ_ESTIMATE),
		.key_lo      (s_tdata[63:0]),
		.key_hi      (s_tdata[127:64]),
		.key_len     (s_tdata[132:128]),
		.amount      (s_tdata[164:133]),
		.row_width   (row_width_q),
		.row_count   (row_count_q),
		.clear_done  (clear_done),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_ctl    (push_ctl),
		.push_addr   (push_addr),
		.push_amount (push_amount)
	);

	cms_back #(
		.MAX_COLUMNS  (MAX_COLUMNS),
		.MAX_ROWS     (MAX_ROWS),
		.COUNTER_BITS (COUNTER_BITS),
		.ADDR_W       (ADDR_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_ctl     (push_ctl),
		.push_addr    (push_addr),
		.push_amount  (push_amount),
		.clear_done   (clear_done),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_estimate (estimate),
		.out_was_new  (was_new),
		.out_distinct (distinct_total)
	);

	// Result packing.
	assign m_tdata = {7'b0, distinct_total, was_new, estimate};
endmodule

### src/cms_ram.sv
module cms_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### src/cms_mul64.sv
module cms_mul64 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        busy,
	output logic [63:0] p
);
	import cms_pkg::*;

	localparam logic [1:0] PH_LL = 2'd0;
	localparam logic [1:0] PH_LH = 2'd1;
	localparam logic [1:0] PH_HL = 2'd2;

	logic [1:0]  phase_q;
	logic        busy_q;
	logic [63:0] a_q, b_q, p_q;
	logic [31:0] ma, mb;
	logic [63:0] prod;

	// One 32x32 multiplier, shared over the three partial products of the low half.
	always_comb begin
		ma   = (phase_q == PH_HL) ? a_q[63:32] : a_q[31:0];
		mb   = (phase_q == PH_LH) ? b_q[63:32] : b_q[31:0];
		prod = ma * mb;
	end

	// Phase control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PH_LL;
		end else if (start) begin
			busy_q  <= 1'b1;
			phase_q <= PH_LL;
		end else if (busy_q) begin
			unique case (phase_q)
				PH_LL: phase_q <= PH_LH;
				PH_LH: phase_q <= PH_HL;
				default: begin
					phase_q <= PH_LL;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	// Operands and accumulated product.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			if (phase_q == PH_LL) begin
				p_q <= prod;
			end else begin
				p_q <= p_q + {prod[31:0], 32'h0};
			end
		end
	end

	assign busy = busy_q;
	assign p    = p_q;
endmodule

### src/cms_front.sv
`include "count_min_sketch_engine_unit_assert.svh"
module cms_front #(
	parameter int unsigned MAX_COLUMNS = cms_pkg::DEF_MAX_COLUMNS,
	parameter int unsigned MAX_ROWS    = cms_pkg::DEF_MAX_ROWS,
	parameter int unsigned ADDR_W      = $clog2(MAX_ROWS * MAX_COLUMNS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  in_is_est,
	input  logic [63:0]           key_lo,
	input  logic [63:0]           key_hi,
	input  logic [4:0]            key_len,
	input  logic signed [31:0]    amount,
	input  logic [12:0]           row_width,
	input  logic [3:0]            row_count,
	input  logic                  clear_done,
	output logic                  push_valid,
	input  logic                  push_ready,
	output cms_pkg::op_ctl_t      push_ctl,
	output logic [ADDR_W-1:0]     push_addr,
	output logic signed [31:0]    push_amount
);
	import cms_pkg::*;

	localparam int unsigned CW  = $clog2(MAX_COLUMNS + 1);
	localparam int unsigned RCW = $clog2(MAX_ROWS + 1);

	// Hash sequencer steps.
	localparam logic [4:0] ST_K1A  = 5'd0;
	localparam logic [4:0] ST_K1B  = 5'd1;
	localparam logic [4:0] ST_K2A  = 5'd2;
	localparam logic [4:0] ST_K2B  = 5'd3;
	localparam logic [4:0] ST_MIX1 = 5'd4;
	localparam logic [4:0] ST_MIX2 = 5'd5;
	localparam logic [4:0] ST_MIX3 = 5'd6;
	localparam logic [4:0] ST_MIX4 = 5'd7;
	localparam logic [4:0] ST_LEN  = 5'd8;
	localparam logic [4:0] ST_ADD0 = 5'd9;
	localparam logic [4:0] ST_F1A  = 5'd10;
	localparam logic [4:0] ST_F1B  = 5'd11;
	localparam logic [4:0] ST_F2A  = 5'd12;
	localparam logic [4:0] ST_F2B  = 5'd13;
	localparam logic [4:0] ST_FIN1 = 5'd14;
	localparam logic [4:0] ST_FIN2 = 5'd15;
	localparam logic [4:0] ST_FIN3 = 5'd16;

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_HASH = 4'b0010,
		F_DIV  = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	fstate_t            state_q;
	logic [4:0]         step_q;
	logic               wait_q;
	logic               is_est_q, op_q, full_q, half_q;
	logic signed [31:0] amount_q;
	logic [63:0]        mlo_q, mhi_q, h1_q, h2_q, k1_q, dv_q;
	logic [4:0]         len_q;
	logic [RCW-1:0]     rows_q, pair_q;
	logic [CW-1:0]      w_q, rem_q;
	logic [3:0]         dcnt_q;

	logic [4:0]     len_sat;
	logic [63:0]    mlo_d, mhi_d;
	logic [RCW-1:0] rows_d;
	logic [CW-1:0]  w_d;
	logic [31:0]    rc32, wc32;
	logic           accept;
	logic           mul_start, mul_busy, mul_step;
	logic [63:0]    mul_a, mul_b, mul_p;
	logic [63:0]    seed, len64;
	logic [CW-1:0]  rem_n;
	logic [CW:0]    trial;
	logic [RCW:0]   row_ext, rows_ext;
	logic           last;

	cms_mul64 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.p      (mul_p)
	);

	// Classify the incoming request: clamp length, mask key bytes, clamp the registers.
	always_comb begin
		len_sat = (key_len > 5'(KEY_BYTES)) ? 5'(KEY_BYTES) : key_len;
		for (int i = 0; i < 8; i++) begin
			mlo_d[8*i +: 8] = (5'(i) < len_sat) ? key_lo[8*i +: 8] : 8'h00;
			mhi_d[8*i +: 8] = (5'(i + 8) < len_sat) ? key_hi[8*i +: 8] : 8'h00;
		end
		rc32   = 32'(row_count);
		wc32   = 32'(row_width);
		rows_d = (rc32 > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(row_count);
		if (wc32 == 32'd0) begin
			w_d = CW'(1);
		end else if (wc32 > MAX_COLUMNS) begin
			w_d = CW'(MAX_COLUMNS);
		end else begin
			w_d = CW'(row_width);
		end
	end

	assign in_ready = (state_q == F_IDLE) && clear_done;
	assign accept   = in_valid && in_ready;
	assign seed     = 64'(pair_q);
	assign len64    = 64'(len_q);

	// Multiplier operands for the steps that start a product.
	always_comb begin
		mul_step = 1'b1;
		mul_a    = '0;
		mul_b    = '0;
		unique case (step_q)
			ST_K1A: begin mul_a = mlo_q;              mul_b = MM_C1;  end
			ST_K1B: begin mul_a = rotl64(mul_p, 31);  mul_b = MM_C2;  end
			ST_K2A: begin mul_a = mhi_q;              mul_b = MM_C2;  end
			ST_K2B: begin mul_a = rotl64(mul_p, 33);  mul_b = MM_C1;  end
			ST_F1A: begin mul_a = xshift33(h1_q);     mul_b = MM_FM1; end
			ST_F1B: begin mul_a = xshift33(mul_p);    mul_b = MM_FM2; end
			ST_F2A: begin mul_a = xshift33(h2_q);     mul_b = MM_FM1; end
			ST_F2B: begin mul_a = xshift33(mul_p);    mul_b = MM_FM2; end
			default: mul_step = 1'b0;
		endcase
		mul_start = (state_q == F_HASH) && mul_step && !wait_q;
	end

	// Four dividend bits folded into the remainder per cycle, most significant first.
	always_comb begin
		rem_n = rem_q;
		trial = '0;
		for (int b = 0; b < 4; b++) begin
			trial = {rem_n, dv_q[63 - b]};
			if (trial >= {1'b0, w_q}) begin
				trial = trial - {1'b0, w_q};
			end
			rem_n = trial[CW-1:0];
		end
	end

	// Row being pushed and whether it closes the request.
	always_comb begin
		row_ext  = {1'b0, pair_q} + (RCW + 1)'(half_q);
		rows_ext = {1'b0, rows_q};
		last     = (row_ext + (RCW + 1)'(1)) >= rows_ext;
	end

	assign push_valid       = (state_q == F_PUSH);
	assign push_ctl.has_op  = op_q;
	assign push_ctl.last    = op_q ? last : 1'b1;
	assign push_ctl.is_est  = is_est_q;
	assign push_addr        = ADDR_W'(row_ext) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(rem_q);
	assign push_amount      = amount_q;

	// Front sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= ST_K1A;
			wait_q  <= 1'b0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						is_est_q <= in_is_est;
						amount_q <= amount;
						mlo_q    <= mlo_d;
						mhi_q    <= mhi_d;
						len_q    <= len_sat;
						full_q   <= (len_sat >= 5'(KEY_BYTES));
						rows_q   <= rows_d;
						w_q      <= w_d;
						pair_q   <= '0;
						half_q   <= 1'b0;
						op_q     <= (rows_d != '0);
						step_q   <= ST_K1A;
						wait_q   <= 1'b0;
						state_q  <= (rows_d != '0) ? F_HASH : F_PUSH;
					end
				end
				F_HASH: begin
					if (mul_step) begin
						if (!wait_q) begin
							wait_q <= 1'b1;
							if (step_q == ST_K2A) begin
								k1_q <= mul_p;
							end
							if (step_q == ST_F2A) begin
								h1_q <= xshift33(mul_p);
							end
						end else if (!mul_busy) begin
							wait_q <= 1'b0;
							step_q <= step_q + 5'd1;
						end
					end else begin
						step_q <= step_q + 5'd1;
						unique case (step_q)
							ST_MIX1: begin
								h1_q <= full_q ? rotl64(seed ^ k1_q, 27) + seed : seed ^ k1_q;
								h2_q <= seed ^ mul_p;
							end
							ST_MIX2: if (full_q) begin
								h1_q <= (h1_q << 2) + h1_q + MM_ADD1;
							end
							ST_MIX3: if (full_q) begin
								h2_q <= rotl64(h2_q, 31) + h1_q;
							end
							ST_MIX4: if (full_q) begin
								h2_q <= (h2_q << 2) + h2_q + MM_ADD2;
							end
							ST_LEN: begin
								h1_q <= (h1_q ^ len64) + (h2_q ^ len64);
								h2_q <= h2_q ^ len64;
							end
							ST_ADD0: h2_q <= h2_q + h1_q;
							ST_FIN1: h2_q <= xshift33(mul_p);
							ST_FIN2: h1_q <= h1_q + h2_q;
							default: begin
								// Final step: h1 is complete, reduce it first.
								h2_q    <= h2_q + h1_q;
								dv_q    <= h1_q;
								rem_q   <= '0;
								dcnt_q  <= '0;
								half_q  <= 1'b0;
								state_q <= F_DIV;
							end
						endcase
					end
				end
				F_DIV: begin
					rem_q  <= rem_n;
					dv_q   <= dv_q << 4;
					dcnt_q <= dcnt_q + 4'd1;
					if (dcnt_q == 4'hF) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (push_ready) begin
						if (!op_q || last) begin
							state_q <= F_IDLE;
						end else if (!half_q) begin
							half_q  <= 1'b1;
							dv_q    <= h2_q;
							rem_q   <= '0;
							dcnt_q  <= '0;
							state_q <= F_DIV;
						end else begin
							half_q  <= 1'b0;
							pair_q  <= pair_q + RCW'(2);
							step_q  <= ST_K1A;
							wait_q  <= 1'b0;
							state_q <= F_HASH;
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	`CMS_ASSERT(a_mul_free_at_start, mul_start, !mul_busy)
	`CMS_ASSERT(a_rem_below_width, push_valid && op_q, rem_q < w_q)
	`CMS_ASSERT(a_row_in_range, push_valid && op_q, row_ext < rows_ext)
endmodule

### src/cms_back.sv
`include "count_min_sketch_engine_unit_assert.svh"
module cms_back #(
	parameter int unsigned MAX_COLUMNS  = cms_pkg::DEF_MAX_COLUMNS,
	parameter int unsigned MAX_ROWS     = cms_pkg::DEF_MAX_ROWS,
	parameter int unsigned COUNTER_BITS = cms_pkg::DEF_COUNTER_BITS,
	parameter int unsigned ADDR_W       = $clog2(MAX_ROWS * MAX_COLUMNS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  cms_pkg::op_ctl_t      push_ctl,
	input  logic [ADDR_W-1:0]     push_addr,
	input  logic signed [31:0]    push_amount,
	output logic                  clear_done,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [31:0]           out_estimate,
	output logic                  out_was_new,
	output logic [31:0]           out_distinct
);
	import cms_pkg::*;

	localparam int unsigned DEPTH  = MAX_ROWS * MAX_COLUMNS;
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	typedef enum logic [3:0] {
		B_CLEAR = 4'b0001,
		B_IDLE  = 4'b0010,
		B_ACT   = 4'b0100,
		B_DONE  = 4'b1000
	} bstate_t;

	bstate_t            state_q;
	logic [ADDR_W-1:0]  clr_q;
	op_ctl_t            q_ctl [QDEPTH];
	logic [ADDR_W-1:0]  q_addr [QDEPTH];
	logic signed [31:0] q_amt [QDEPTH];
	logic [QAW-1:0]     wp_q, rp_q;
	logic [QAW:0]       cnt_q;
	op_ctl_t            ctl_q;
	logic [ADDR_W-1:0]  addr_q;
	logic signed [31:0] amt_q;
	logic [COUNTER_BITS-1:0] min_q;
	logic               fresh_q;
	logic [31:0]        distinct_q;
	logic               out_valid_q;
	logic [31:0]        est_q, dist_out_q;
	logic               new_q;

	logic                    push_fire, pop_fire, out_free, item_new;
	logic                    ram_we;
	logic [ADDR_W-1:0]       ram_waddr;
	logic [COUNTER_BITS-1:0] ram_wdata, ram_rdata;
	logic [63:0]             amt64, min64;

	cms_ram #(
		.WIDTH (COUNTER_BITS),
		.DEPTH (DEPTH),
		.AW    (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (q_addr[rp_q]),
		.rdata (ram_rdata)
	);

	assign push_ready = (cnt_q != (QAW + 1)'(QDEPTH));
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = (state_q == B_IDLE) && (cnt_q != '0);
	assign out_free   = !out_valid_q || out_ready;
	assign clear_done = (state_q != B_CLEAR);
	assign amt64      = 64'(amt_q);
	assign min64      = 64'(min_q);
	assign item_new   = !ctl_q.is_est && fresh_q;

	// Store writes: zero sweep after reset, otherwise the increase of one counter.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = ram_rdata + amt64[COUNTER_BITS-1:0];
		if (state_q == B_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == B_ACT && !ctl_q.is_est) begin
			ram_we = 1'b1;
		end
	end

	// Request queue between front and back.
	always_ff @(posedge clk) begin
		if (push_fire) begin
			q_ctl[wp_q]  <= push_ctl;
			q_addr[wp_q] <= push_addr;
			q_amt[wp_q]  <= push_amount;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_fire) begin
				wp_q <= wp_q + QAW'(1);
			end
			if (pop_fire) begin
				rp_q <= rp_q + QAW'(1);
			end
			cnt_q <= cnt_q + (QAW + 1)'(push_fire) - (QAW + 1)'(pop_fire);
		end
	end

	// Read-modify-write sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			min_q       <= '1;
			fresh_q     <= 1'b0;
			distinct_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A taken result empties the output register unless a new one is posted now.
			if (out_valid_q && out_ready && state_q != B_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (pop_fire) begin
						ctl_q   <= q_ctl[rp_q];
						addr_q  <= q_addr[rp_q];
						amt_q   <= q_amt[rp_q];
						state_q <= q_ctl[rp_q].has_op ? B_ACT : B_DONE;
					end
				end
				B_ACT: begin
					if (ctl_q.is_est) begin
						if (ram_rdata < min_q) begin
							min_q <= ram_rdata;
						end
					end else if (ram_rdata == '0) begin
						fresh_q <= 1'b1;
					end
					state_q <= ctl_q.last ? B_DONE : B_IDLE;
				end
				B_DONE: begin
					if (out_free) begin
						est_q       <= ctl_q.is_est ? min64[31:0] : 32'd0;
						new_q       <= item_new;
						dist_out_q  <= distinct_q + 32'(item_new);
						distinct_q  <= distinct_q + 32'(item_new);
						out_valid_q <= 1'b1;
						min_q       <= '1;
						fresh_q     <= 1'b0;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign out_estimate = est_q;
	assign out_was_new  = new_q;
	assign out_distinct = dist_out_q;

	`CMS_ASSERT(a_write_only_on_increase, ram_we && state_q != B_CLEAR, state_q == B_ACT && !ctl_q.is_est)
	`CMS_ASSERT(a_queue_bound, 1'b1, cnt_q <= (QAW + 1)'(QDEPTH))
	`CMS_ASSERT(a_no_request_while_clearing, state_q == B_CLEAR, !push_valid)
endmodule
